@@ hw/rtl/spk_pkg.sv @@
// Shared widths, status codes, register indexes and the scan token type.
`default_nettype none
package spk_pkg;

  localparam int DIM_W   = 13;  // pixel sizes and fill columns
  localparam int POS_W   = 12;  // reported and stored positions
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int TALL_SHIFT = 3;  // shelf slack is h / 8

  localparam int MAX_SHELVES_DEF = 64;

  localparam logic [DIM_W-1:0] PAGE_SIZE_RST = 13'd2048;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_PLACED     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NEW_SHELF  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PAGE_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 1'd1;

  // request token that walks the shelf chain
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } tok_t;

endpackage
`default_nettype wire

@@ hw/rtl/spk_channels.sv @@
// Channel interfaces: request, result and configuration write.
`default_nettype none
interface spk_in_if;
  logic                     valid;
  logic                     ready;
  logic [spk_pkg::DIM_W-1:0] rect_width;
  logic [spk_pkg::DIM_W-1:0] rect_height;
  modport source (output valid, rect_width, rect_height, input ready);
  modport sink   (input valid, rect_width, rect_height, output ready);
endinterface

interface spk_out_if;
  logic                      valid;
  logic                      ready;
  logic [spk_pkg::STAT_W-1:0] status;
  logic [spk_pkg::POS_W-1:0]  pos_x;
  logic [spk_pkg::POS_W-1:0]  pos_y;
  modport source (output valid, status, pos_x, pos_y, input ready);
  modport sink   (input valid, status, pos_x, pos_y, output ready);
endinterface

interface spk_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spk_pkg::CFG_IDX_W-1:0] index;
  logic [spk_pkg::DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/spk_cell.sv @@
// One shelf cell: holds a shelf, tests the passing token and hands it on.
`default_nettype none
module spk_cell #(
  parameter int CNT_W = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [spk_pkg::DIM_W-1:0] page_width,
  input  wire logic [spk_pkg::DIM_W-1:0] new_tall,
  input  wire logic [spk_pkg::DIM_W-1:0] next_row,
  input  wire logic                      page_fits,
  input  wire spk_pkg::tok_t             tok_i,
  input  wire logic [CNT_W-1:0]          rem_i,
  output spk_pkg::tok_t                  tok_o,
  output logic [CNT_W-1:0]               rem_o
);

  logic [spk_pkg::POS_W-1:0] top_r;
  logic [spk_pkg::DIM_W-1:0] tall_r;
  logic [spk_pkg::DIM_W-1:0] fill_r;

  spk_pkg::tok_t          tok_r, tok_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic                   occupied;
  logic                   live;
  logic                   hit;
  logic                   open;
  logic [spk_pkg::DIM_W:0] fill_end;

  // shelf i is in use while the count carried with the token is nonzero
  assign occupied = (rem_i != '0);
  assign live     = tok_i.valid && !tok_i.done;
  assign fill_end = {1'b0, fill_r} + {1'b0, tok_i.w};
  assign hit      = live && occupied && (tok_i.h <= tall_r) &&
                    (fill_end <= {1'b0, page_width});
  assign open     = live && !occupied && page_fits;

  // mark the token with the placement made here
  always_comb begin
    tok_nxt = tok_i;
    rem_nxt = occupied ? rem_i - 1'b1 : '0;
    if (hit) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = spk_pkg::STAT_PLACED;
      tok_nxt.x      = fill_r[spk_pkg::POS_W-1:0];
      tok_nxt.y      = top_r;
    end else if (open) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = spk_pkg::STAT_NEW_SHELF;
      tok_nxt.x      = '0;
      tok_nxt.y      = next_row[spk_pkg::POS_W-1:0];
    end
  end

  // shelf storage: advance fill on a hit, load a fresh shelf on open
  always_ff @(posedge clk) begin
    if (hit) begin
      fill_r <= fill_end[spk_pkg::DIM_W-1:0];
    end else if (open) begin
      top_r  <= next_row[spk_pkg::POS_W-1:0];
      tall_r <= new_tall;
      fill_r <= tok_i.w;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  assign tok_o = tok_r;
  assign rem_o = rem_r;

endmodule
`default_nettype wire

@@ hw/rtl/shelf_rectangle_packer.sv @@
// Shelf packer top level: request intake, shelf cell chain, result register.
`default_nettype none
// Places rectangles on an atlas page by first-fit shelves. Each request walks a
// chain of MAX_SHELVES shelf cells, one cell per clock, in shelf creation order;
// the first open shelf with height and room takes it, otherwise the first empty
// cell opens a new shelf if the page has rows left. One request is in flight at
// a time: its token walks the whole cell chain before its result is registered,
// and the next request is taken only after the token leaves the chain, so the
// block cannot take a new request before it is through with the last one, and
// a result may also wait for the sink. A new request is taken as soon as the
// previous result has left or is leaving the output register. Page size
// registers are written through the configuration port, which is always ready,
// and should change only while no request is in flight.
module shelf_rectangle_packer #(
  parameter int MAX_SHELVES = spk_pkg::MAX_SHELVES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spk_cfg_if.sink    cfg_chan,
  spk_in_if.sink     in_chan,
  spk_out_if.source  out_chan
);

  localparam int CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int DW    = spk_pkg::DIM_W;

  logic [DW-1:0]     page_w_r, page_h_r;
  logic [CNT_W-1:0]  count_r;
  logic [DW-1:0]     next_row_r;
  logic              busy_r;
  logic              ent_vld_r;
  logic [DW-1:0]     w_r, h_r;
  logic [DW:0]       tall_r;
  logic              page_fits;
  logic              in_acc;
  logic              out_free;

  logic                       out_vld_r;
  logic [spk_pkg::STAT_W-1:0] out_stat_r;
  logic [spk_pkg::POS_W-1:0]  out_x_r, out_y_r;

  spk_pkg::tok_t    head;
  spk_pkg::tok_t    tok   [MAX_SHELVES+1];
  logic [CNT_W-1:0] rem   [MAX_SHELVES+1];
  logic [MAX_SHELVES:0] tok_vld;
  spk_pkg::tok_t    tail;

  // configuration writes
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_w_r <= spk_pkg::PAGE_SIZE_RST;
      page_h_r <= spk_pkg::PAGE_SIZE_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        spk_pkg::REG_PAGE_WIDTH:  page_w_r <= cfg_chan.data;
        spk_pkg::REG_PAGE_HEIGHT: page_h_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // accept a request when idle and the output slot frees up
  assign out_free      = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !busy_r && out_free;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // latch request and its would-be shelf height
  always_ff @(posedge clk) begin
    if (in_acc) begin
      w_r    <= in_chan.rect_width;
      h_r    <= in_chan.rect_height;
      tall_r <= {1'b0, in_chan.rect_height} +
                {{(spk_pkg::TALL_SHIFT+1){1'b0}},
                 in_chan.rect_height[DW-1:spk_pkg::TALL_SHIFT]};
    end
  end

  // does a new shelf of this height still fit on the page
  assign page_fits = ({2'b00, next_row_r} + {1'b0, tall_r}) <= {2'b00, page_h_r};

  // token entering the first cell
  always_comb begin
    head        = '0;
    head.valid  = ent_vld_r;
    head.status = spk_pkg::STAT_PLACED;
    head.w      = w_r;
    head.h      = h_r;
  end

  assign tok[0] = head;
  assign rem[0] = count_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SHELVES; gi++) begin : g_cell
      spk_cell #(
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .page_width (page_w_r),
        .new_tall   (tall_r[DW-1:0]),
        .next_row   (next_row_r),
        .page_fits  (page_fits),
        .tok_i      (tok[gi]),
        .rem_i      (rem[gi]),
        .tok_o      (tok[gi+1]),
        .rem_o      (rem[gi+1])
      );
    end
    for (gi = 0; gi <= MAX_SHELVES; gi++) begin : g_vld
      assign tok_vld[gi] = tok[gi].valid;
    end
  endgenerate

  assign tail = tok[MAX_SHELVES];

  // control: busy flag, shelf count and next free row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      ent_vld_r  <= 1'b0;
      count_r    <= '0;
      next_row_r <= '0;
    end else begin
      ent_vld_r <= in_acc;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (tail.valid) begin
        busy_r <= 1'b0;
      end
      if (tail.valid && tail.done && tail.status == spk_pkg::STAT_NEW_SHELF) begin
        count_r    <= count_r + 1'b1;
        next_row_r <= next_row_r + tall_r[DW-1:0];
      end
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (tail.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      if (tail.done) begin
        out_stat_r <= tail.status;
        out_x_r    <= tail.x;
        out_y_r    <= tail.y;
      end else begin
        out_stat_r <= page_fits ? spk_pkg::STAT_TABLE_FULL : spk_pkg::STAT_PAGE_FULL;
        out_x_r    <= '0;
        out_y_r    <= '0;
      end
    end
  end

  assign out_chan.valid  = out_vld_r;
  assign out_chan.status = out_stat_r;
  assign out_chan.pos_x  = out_x_r;
  assign out_chan.pos_y  = out_y_r;

  // at most one request walks the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld) <= 1)
    else $error("more than one token in shelf chain");

  // a token leaves the chain only while a request is in flight
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> busy_r)
    else $error("token left chain with no request in flight");

  // shelf count never passes the table size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SHELVES))
    else $error("shelf count overflow");

  // a finished result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> out_free)
    else $error("result register overrun");

  // a new shelf always starts at column zero
  a_new_x0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stat_r == spk_pkg::STAT_NEW_SHELF) |-> (out_x_r == '0))
    else $error("new shelf placement not at column zero");

endmodule
`default_nettype wire

@@ dv/shelf_rectangle_packer_tb.sv @@
// Testbench for the shelf packer: predicts every placement and checks each result word.
module shelf_rectangle_packer_tb;

  localparam int DW = spk_pkg::DIM_W;
  localparam int SHELF_SLOTS = spk_pkg::MAX_SHELVES_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_RECTS = 125;
  localparam int PHASE_COUNT = 14;

  typedef struct packed {
    logic [spk_pkg::STAT_W-1:0] status;
    logic [spk_pkg::POS_W-1:0]  pos_x;
    logic [spk_pkg::POS_W-1:0]  pos_y;
  } placement_t;

  // Shelf table model plus the queue of placements still owed by the block
  class placement_scoreboard;
    logic [DW-1:0]             page_w;
    logic [DW-1:0]             page_h;
    logic [spk_pkg::POS_W-1:0] shelf_row[SHELF_SLOTS];
    logic [DW-1:0]             shelf_span[SHELF_SLOTS];
    logic [DW-1:0]             shelf_fill[SHELF_SLOTS];
    int unsigned               shelves_used;
    logic [DW-1:0]             free_row;
    placement_t                expected_placements[$];
    int                        errors;

    function new();
      page_w = spk_pkg::PAGE_SIZE_RST;
      page_h = spk_pkg::PAGE_SIZE_RST;
      shelves_used = 0;
      free_row = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [spk_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] value);
      case (idx)
        spk_pkg::REG_PAGE_WIDTH: page_w = value;
        spk_pkg::REG_PAGE_HEIGHT: page_h = value;
        default: ;
      endcase
    endfunction

    // First-fit over existing shelves, else open a shelf below the last one
    function placement_t place_rect(logic [DW-1:0] w, logic [DW-1:0] h);
      placement_t  res;
      int unsigned i;
      int unsigned wu;
      int unsigned hu;
      int unsigned span;
      res = '{status: spk_pkg::STAT_PAGE_FULL, pos_x: '0, pos_y: '0};
      wu = w;
      hu = h;
      for (i = 0; i < shelves_used; i++) begin
        if (hu <= int'(shelf_span[i]) && int'(shelf_fill[i]) + wu <= int'(page_w)) begin
          res.status = spk_pkg::STAT_PLACED;
          res.pos_x = shelf_fill[i][spk_pkg::POS_W-1:0];
          res.pos_y = shelf_row[i];
          shelf_fill[i] = shelf_fill[i] + w;
          return res;
        end
      end
      span = hu + (hu >> spk_pkg::TALL_SHIFT);
      if (int'(free_row) + span > int'(page_h)) return res;
      if (shelves_used >= SHELF_SLOTS) begin
        res.status = spk_pkg::STAT_TABLE_FULL;
        return res;
      end
      res.status = spk_pkg::STAT_NEW_SHELF;
      res.pos_y = free_row[spk_pkg::POS_W-1:0];
      shelf_row[shelves_used] = free_row[spk_pkg::POS_W-1:0];
      shelf_span[shelves_used] = span[DW-1:0];
      shelf_fill[shelves_used] = w;
      shelves_used++;
      free_row = free_row + span[DW-1:0];
      return res;
    endfunction

    function void note_request(logic [DW-1:0] w, logic [DW-1:0] h);
      placement_t p;
      p = place_rect(w, h);
      expected_placements = {expected_placements, p};
    endfunction

    function void check_result(logic [spk_pkg::STAT_W-1:0] st, logic [spk_pkg::POS_W-1:0] x,
                               logic [spk_pkg::POS_W-1:0] y);
      placement_t exp_p;
      if (expected_placements.size() == 0) begin
        $error("result with nothing expected: status %0d pos_x %0d pos_y %0d", st, x, y);
        errors++;
        return;
      end
      exp_p = expected_placements.pop_front();
      if (st !== exp_p.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_p.status, st);
        errors++;
      end
      if (x !== exp_p.pos_x) begin
        $error("pos_x mismatch: expected %0d, actual %0d", exp_p.pos_x, x);
        errors++;
      end
      if (y !== exp_p.pos_y) begin
        $error("pos_y mismatch: expected %0d, actual %0d", exp_p.pos_y, y);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic res_ready = 1'b0;
  int   hold_off = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   quiet_cycles = 0;

  placement_scoreboard sb = new();

  spk_cfg_if cfg_bus();
  spk_in_if  in_bus();
  spk_out_if out_bus();

  shelf_rectangle_packer #(.MAX_SHELVES(SHELF_SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus.sink),
    .in_chan  (in_bus.sink),
    .out_chan (out_bus.source)
  );

  always #2 clk = ~clk;

  assign out_bus.ready = res_ready;

  // Stall the result side in bursts of random length
  always @(posedge clk) begin
    if (hold_off != 0) begin
      res_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      res_ready <= 1'b0;
      hold_off <= $urandom_range(0, 7);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check_result(out_bus.status, out_bus.pos_x, out_bus.pos_y);
    end
  end

  // End the run when no channel moves a word for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write both page size registers back to back, then drop valid
  task automatic write_page(input logic [DW-1:0] w, input logic [DW-1:0] h);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= spk_pkg::REG_PAGE_WIDTH;
    cfg_bus.data <= w;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.set_reg(spk_pkg::REG_PAGE_WIDTH, w);
    cfg_bus.index <= spk_pkg::REG_PAGE_HEIGHT;
    cfg_bus.data <= h;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.set_reg(spk_pkg::REG_PAGE_HEIGHT, h);
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer one request word, hold it until taken, then maybe idle a burst
  task automatic feed_rect(input logic [DW-1:0] w, input logic [DW-1:0] h);
    in_bus.valid <= 1'b1;
    in_bus.rect_width <= w;
    in_bus.rect_height <= h;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_request(w, h);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every placement has come back
  task automatic drain_requests();
    in_bus.valid <= 1'b0;
    while (sb.expected_placements.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pw;
    int ph;
    int sel;
    logic [DW-1:0] w;
    logic [DW-1:0] h;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.rect_width <= '0;
    in_bus.rect_height <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= spk_pkg::REG_PAGE_WIDTH;
    cfg_bus.data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset page size: zero sizes, exact fits, unchecked
    // width on a new shelf, slack rounding and page overflow
    in_idle_pct = 30;
    out_idle_pct = 30;
    feed_rect(13'd0, 13'd0);
    feed_rect(13'd0, 13'd0);
    feed_rect(13'd10, 13'd0);
    feed_rect(13'd5, 13'd8);
    feed_rect(13'd2048, 13'd1);
    feed_rect(13'd4096, 13'd4);
    feed_rect(13'd0, 13'd4);
    feed_rect(13'd2043, 13'd9);
    feed_rect(13'd1, 13'd9);
    feed_rect(13'd8191, 13'd4095);
    feed_rect(13'd4096, 13'd4096);
    feed_rect(13'd0, 13'd8191);
    feed_rect(13'd4095, 13'd1799);
    feed_rect(13'd1, 13'd7);
    feed_rect(13'd3, 13'd7);
    feed_rect(13'd4095, 13'd1);
    feed_rect(13'd7, 13'd4095);
    feed_rect(13'd100, 13'd16);
    feed_rect(13'd100, 13'd16);
    feed_rect(13'd8191, 13'd0);
    drain_requests();

    // Random phases: page grows from the smallest to past the nominal range
    for (int k = 0; k < PHASE_COUNT; k++) begin
      if (k == 0) begin
        pw = 1;
        ph = 1;
      end else if (k == PHASE_COUNT - 2) begin
        pw = 4096;
        ph = 4096;
      end else if (k == PHASE_COUNT - 1) begin
        pw = 8191;
        ph = 8191;
      end else begin
        pw = 350 * k + $urandom_range(0, 349);
        ph = 170 * k + $urandom_range(0, 169);
      end
      write_page(pw[DW-1:0], ph[DW-1:0]);
      if (k == PHASE_COUNT - 1) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        sel = $urandom_range(0, 2);
        in_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
        sel = $urandom_range(0, 2);
        out_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
      end
      for (int n = 0; n < PHASE_RECTS; n++) begin
        sel = $urandom_range(0, 9);
        w = (sel < 7) ? DW'($urandom_range(0, 64)) :
            (sel < 9) ? DW'($urandom_range(0, 1024)) : DW'($urandom_range(0, 8191));
        sel = $urandom_range(0, 9);
        h = (sel < 7) ? DW'($urandom_range(0, 24)) :
            (sel < 9) ? DW'($urandom_range(0, 300)) : DW'($urandom_range(0, 8191));
        feed_rect(w, h);
      end
      drain_requests();
    end

    // Let any stray word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_placements.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/spk_pkg.sv
hw/rtl/spk_channels.sv
hw/rtl/spk_cell.sv
hw/rtl/shelf_rectangle_packer.sv
dv/shelf_rectangle_packer_tb.sv
